### design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and defaults for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int unsigned MEXP_WIDTH = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULTIPLY,
        ST_FINISH
    } mexp_state_t;

endpackage

### design/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// A zero exponent or modulus goes straight to ST_FINISH; otherwise the base is
//   reduced, then each exponent bit, MSB first, squares acc and multiplies if set.
// Throughput: one transaction in flight; set by the single shift-add modular
//   multiplier, which retires one multiplier bit per cycle.
// Reset: aresetn low, synchronous, returns the sequencer to idle and drops m_valid.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int unsigned WIDTH = mexp_pkg::MEXP_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [WIDTH-1:0] s_base_value,
    input  logic [WIDTH-1:0] s_exponent,
    input  logic [WIDTH-1:0] s_modulus,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [WIDTH-1:0] m_residue
);
    import mexp_pkg::*;

    localparam int unsigned CW = $clog2(WIDTH);

    mexp_state_t state_reg, state_next;

    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] exp_reg, exp_next;
    logic [WIDTH-1:0] mod_reg, mod_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] mul_a_reg, mul_a_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [CW-1:0]    step_reg, step_next;
    logic [CW-1:0]    bit_reg, bit_next;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] out_data_reg, out_data_next;

    // shared multiplier step: r = (2r + a_msb*x) mod m, with r < m and x <= m
    logic [WIDTH-1:0] mul_x;
    logic [WIDTH+1:0] t, mod_ext, mod_dbl, d1, d2;
    logic [WIDTH-1:0] prod;
    logic             step_last, bit_last, out_free;

    always_comb begin
        case (state_reg)
            ST_REDUCE: mul_x = WIDTH'(1);
            ST_SQUARE: mul_x = acc_reg;
            default:   mul_x = base_reg;
        endcase
        mod_ext = {2'b00, mod_reg};
        mod_dbl = {1'b0, mod_reg, 1'b0};
        t  = {1'b0, r_reg, 1'b0} + (mul_a_reg[WIDTH-1] ? {2'b00, mul_x} : '0);
        d1 = t - mod_ext;
        d2 = t - mod_dbl;
        if (t >= mod_dbl) begin
            prod = d2[WIDTH-1:0];
        end else if (t >= mod_ext) begin
            prod = d1[WIDTH-1:0];
        end else begin
            prod = t[WIDTH-1:0];
        end
    end

    assign step_last = (step_reg == CW'(WIDTH - 1));
    assign bit_last  = (bit_reg == '0);
    assign out_free  = !out_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_exponent == '0 || s_modulus == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (step_last) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (step_last) begin
                    if (exp_reg[WIDTH-1]) begin
                        state_next = ST_MULTIPLY;
                    end else if (bit_last) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_MULTIPLY: begin
                if (step_last) begin
                    state_next = bit_last ? ST_FINISH : ST_SQUARE;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        base_next      = base_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        acc_next       = acc_reg;
        mul_a_next     = mul_a_reg;
        r_next         = r_reg;
        step_next      = step_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    base_next  = s_base_value;
                    exp_next   = s_exponent;
                    mod_next   = s_modulus;
                    mul_a_next = s_base_value;
                    r_next     = '0;
                    step_next  = '0;
                    bit_next   = CW'(WIDTH - 1);
                    acc_next   = (s_exponent == '0) ? WIDTH'(1) : '0;
                end
            end
            ST_REDUCE: begin
                r_next     = prod;
                mul_a_next = mul_a_reg << 1;
                step_next  = step_reg + CW'(1);
                if (step_last) begin
                    base_next  = prod;
                    acc_next   = (mod_reg == WIDTH'(1)) ? '0 : WIDTH'(1);
                    mul_a_next = (mod_reg == WIDTH'(1)) ? '0 : WIDTH'(1);
                    r_next     = '0;
                    step_next  = '0;
                end
            end
            ST_SQUARE, ST_MULTIPLY: begin
                r_next     = prod;
                mul_a_next = mul_a_reg << 1;
                step_next  = step_reg + CW'(1);
                if (step_last) begin
                    acc_next   = prod;
                    mul_a_next = prod;
                    r_next     = '0;
                    step_next  = '0;
                    if (state_reg == ST_MULTIPLY || !exp_reg[WIDTH-1]) begin
                        exp_next = exp_reg << 1;
                        bit_next = bit_reg - CW'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            bit_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            bit_reg       <= bit_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg     <= base_next;
        exp_reg      <= exp_next;
        mod_reg      <= mod_next;
        acc_reg      <= acc_next;
        mul_a_reg    <= mul_a_next;
        r_reg        <= r_next;
        out_data_reg <= out_data_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_residue = out_data_reg;

    // partial product stays reduced while the multiplier runs
    a_partial_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REDUCE || state_reg == ST_SQUARE || state_reg == ST_MULTIPLY)
        |-> (r_reg < mod_reg))
        else $error("partial product not below modulus");

    // operands of every square/multiply are residues
    a_operands_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQUARE || state_reg == ST_MULTIPLY)
        |-> (acc_reg < mod_reg && base_reg < mod_reg))
        else $error("exponentiation operand not reduced");

    // an accepted transaction blocks the input until it is finished
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while busy");

endmodule
